// File: design/rip_pkg.sv
package rip_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 6;
  localparam int unsigned RadixW = 6;
  localparam int unsigned AccW   = 64;
  localparam int unsigned NarrowW = 32;
  localparam int unsigned ProdW  = AccW + RadixW + 1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic              WideReset  = 1'b1;

  localparam logic RegRadix    = 1'b0;
  localparam logic RegWideMode = 1'b1;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] UpBias  = ChUpA - 8'd10;
  localparam logic [CharW-1:0] LowBias = ChLowA - 8'd10;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              bad;
    logic              last;
    logic [RadixW-1:0] base;
    logic              wide;
  } entry_t;

endpackage

// File: design/radix_integer_parser.sv
// Channel  | dir | handshake             | payload
// s_axis   | in  | s_axis_tvalid/tready  | tdata: char_code[7:0]; tlast: last_char
// m_axis   | out | m_axis_tvalid/tready  | tdata: number_value[63:0]; tuser: parse_ok
// cfg      | in  | cfg_valid_i/ready_o   | cfg_index_i (0 radix, 1 wide_mode), cfg_data_i
//
// One character per cycle. The front decodes the character and clamps the radix
// into a 2-entry queue; the back does one 64x6 multiply-add and limit check per
// cycle unless stalled; a last character passes the queue, then the output register.
// Reset clears the run state and sets radix 10, wide_mode 1. s_axis stalls only
// when the queue is full; the back stalls only on a last character while a
// result still waits in the output register.
module radix_integer_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rip_pkg::CharW-1:0]    s_axis_tdata,  // char_code[7:0]
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rip_pkg::AccW-1:0]     m_axis_tdata,  // number_value[63:0]
  output logic                         m_axis_tuser,  // parse_ok
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [rip_pkg::RadixW-1:0]   cfg_data_i
);
  import rip_pkg::*;

  entry_t front_entry;
  entry_t q_entry;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   push;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  rip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .entry_o     (front_entry)
  );

  rip_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  rip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (m_axis_tdata),
    .ok_o        (m_axis_tuser)
  );

endmodule

// File: design/rip_front.sv
module rip_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_index_i,
  input  logic [rip_pkg::RadixW-1:0]   cfg_data_i,
  input  logic [rip_pkg::CharW-1:0]    char_i,
  input  logic                         last_i,
  output rip_pkg::entry_t              entry_o
);
  import rip_pkg::*;

  logic [RadixW-1:0] radix_q, radix_d;
  logic              wide_q, wide_d;
  logic [RadixW-1:0] base;
  logic [CharW-1:0]  dval;
  logic              is_digit;

  always_comb begin
    radix_d = radix_q;
    wide_d  = wide_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRadix:    radix_d = cfg_data_i;
        RegWideMode: wide_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      wide_q  <= WideReset;
    end else begin
      radix_q <= radix_d;
      wide_q  <= wide_d;
    end
  end

  always_comb begin
    if (radix_q < RadixMin)      base = RadixMin;
    else if (radix_q > RadixMax) base = RadixMax;
    else                         base = radix_q;

    is_digit = 1'b1;
    if (char_i >= ChZero && char_i <= ChNine)      dval = char_i - ChZero;
    else if (char_i >= ChUpA && char_i <= ChUpZ)   dval = char_i - UpBias;
    else if (char_i >= ChLowA && char_i <= ChLowZ) dval = char_i - LowBias;
    else begin
      dval     = '0;
      is_digit = 1'b0;
    end

    entry_o.digit = dval[DigitW-1:0];
    entry_o.bad   = !is_digit || (dval[DigitW-1:0] >= base);
    entry_o.last  = last_i;
    entry_o.base  = base;
    entry_o.wide  = wide_q;
  end

endmodule

// File: design/rip_fifo.sv
module rip_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rip_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rip_pkg::entry_t data_o
);
  import rip_pkg::*;

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: design/rip_back.sv
module rip_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  rip_pkg::entry_t          entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [rip_pkg::AccW-1:0] value_o,
  output logic                     ok_o
);
  import rip_pkg::*;

  logic [AccW-1:0]  acc_q, acc_d;
  logic             ovf_q, ovf_d;
  logic             bad_q, bad_d;
  logic             ovalid_q, ovalid_d;
  logic [AccW-1:0]  oval_q, oval_d;
  logic             ook_q, ook_d;
  logic [ProdW-1:0] sum;
  logic             over;
  logic             ok;

  assign pop_o = valid_i && (!entry_i.last || !ovalid_q || out_ready_i);

  always_comb begin
    sum  = ProdW'(acc_q) * ProdW'(entry_i.base) + ProdW'(entry_i.digit);
    over = entry_i.wide ? (|sum[ProdW-1:AccW]) : (|sum[ProdW-1:NarrowW]);

    acc_d    = acc_q;
    ovf_d    = ovf_q;
    bad_d    = bad_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oval_d   = oval_q;
    ook_d    = ook_q;
    ok       = 1'b0;

    if (pop_o) begin
      if (entry_i.bad) bad_d = 1'b1;
      else if (!ovf_q) begin
        if (over) ovf_d = 1'b1;
        else      acc_d = sum[AccW-1:0];
      end
      if (entry_i.last) begin
        ok       = !bad_d && !ovf_d;
        ovalid_d = 1'b1;
        oval_d   = ok ? acc_d : '0;
        ook_d    = ok;
        acc_d    = '0;
        ovf_d    = 1'b0;
        bad_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      bad_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      ovf_q    <= ovf_d;
      bad_q    <= bad_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q <= oval_d;
    ook_q  <= ook_d;
  end

  assign out_valid_o = ovalid_q;
  assign value_o     = oval_q;
  assign ok_o        = ook_q;

endmodule

// File: test/rip_checker.sv
`timescale 1ns / 100ps

module rip_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [rip_pkg::CharW-1:0]  s_axis_tdata,   // char_code[7:0]
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [rip_pkg::AccW-1:0]   m_axis_tdata,   // number_value[63:0]
  input  logic                       m_axis_tuser,   // parse_ok
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic                       cfg_index_i,
  input  logic [rip_pkg::RadixW-1:0] cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  import rip_pkg::*;

  localparam int unsigned NoDigit = 255;

  typedef struct packed {
    logic [AccW-1:0] value;
    logic            ok;
  } parsed_t;

  parsed_t           parsed_q[$];
  logic [RadixW-1:0] radix_r = RadixReset;
  logic              wide_r  = WideReset;
  logic [AccW-1:0]   acc_r   = '0;
  logic              ovf_r   = 1'b0;
  logic              bad_r   = 1'b0;
  int unsigned       errors  = 0;

  assign fail_count_o = errors;

  function automatic int unsigned char_digit(input logic [CharW-1:0] ch);
    if (ch >= ChZero && ch <= ChNine) return 32'(ch - ChZero);
    if (ch >= ChUpA && ch <= ChUpZ) return 32'(ch - UpBias);
    if (ch >= ChLowA && ch <= ChLowZ) return 32'(ch - LowBias);
    return NoDigit;
  endfunction

  task automatic report_mismatch(input string what, input logic [AccW-1:0] got,
                                 input logic [AccW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic absorb_char(input logic [CharW-1:0] ch, input logic last);
    logic [AccW-1:0] base;
    logic [AccW-1:0] limit;
    logic [AccW-1:0] cutoff;
    logic [AccW-1:0] cutlim;
    int unsigned     d;
    parsed_t         res;
    if (radix_r < RadixMin) base = 64'(RadixMin);
    else if (radix_r > RadixMax) base = 64'(RadixMax);
    else base = 64'(radix_r);
    limit = wide_r ? '1 : {{(AccW-NarrowW){1'b0}}, {NarrowW{1'b1}}};
    d = char_digit(ch);
    if (d == NoDigit || 64'(d) >= base) begin
      bad_r = 1'b1;
    end else if (!ovf_r) begin
      cutoff = limit / base;
      cutlim = limit % base;
      if (acc_r > cutoff || (acc_r == cutoff && 64'(d) > cutlim)) ovf_r = 1'b1;
      else acc_r = acc_r * base + 64'(d);
    end
    if (last) begin
      res.ok    = !bad_r && !ovf_r;
      res.value = res.ok ? acc_r : '0;
      parsed_q.push_back(res);
      acc_r = '0;
      ovf_r = 1'b0;
      bad_r = 1'b0;
    end
  endtask

  task automatic check_result();
    parsed_t want;
    if (parsed_q.size() == 0) begin
      report_mismatch("unexpected word", m_axis_tdata, '0);
    end else begin
      want = parsed_q.pop_front();
      if (m_axis_tdata !== want.value) report_mismatch("number_value", m_axis_tdata, want.value);
      if (m_axis_tuser !== want.ok) report_mismatch("parse_ok", 64'(m_axis_tuser), 64'(want.ok));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_r = RadixReset;
      wide_r  = WideReset;
      acc_r   = '0;
      ovf_r   = 1'b0;
      bad_r   = 1'b0;
      parsed_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegRadix) radix_r = cfg_data_i;
        else wide_r = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) absorb_char(s_axis_tdata, s_axis_tlast);
      pending_o <= parsed_q.size();
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rip_pkg::*;

  localparam int unsigned TotalItems = 1875;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [CharW-1:0]  s_axis_tdata  = '0;   // char_code[7:0]
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [AccW-1:0]   m_axis_tdata;         // number_value[63:0]
  logic              m_axis_tuser;         // parse_ok
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i   = RegRadix;
  logic [RadixW-1:0] cfg_data_i    = '0;

  int unsigned       fail_count;
  int unsigned       pending;
  logic [RadixW-1:0] cur_radix = RadixReset;
  logic              cur_wide  = WideReset;
  bit                quiet     = 1'b0;
  int unsigned       rx_hold   = 0;
  int unsigned       sent      = 0;
  logic [7:0]        text_q[$];

  radix_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rip_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          m_axis_tready <= 1'b0;
          rx_hold <= $urandom_range(10, 40);
        end
        1, 2, 3: begin
          m_axis_tready <= 1'b0;
          rx_hold <= $urandom_range(0, 2);
        end
        default: begin
          m_axis_tready <= 1'b1;
          rx_hold <= $urandom_range(0, 7);
        end
      endcase
    end
  end

  function automatic int unsigned eff_base();
    if (cur_radix < RadixMin) return 32'(RadixMin);
    if (cur_radix > RadixMax) return 32'(RadixMax);
    return 32'(cur_radix);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(0, 1) ? UpBias : LowBias) + 8'(d);
  endfunction

  // non-digit ranges around 0-9, A-Z, a-z, high codes, or digit >= base
  function automatic logic [7:0] bad_char(input int unsigned b);
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(0, 47));
      2: return 8'($urandom_range(58, 64));
      3: return 8'($urandom_range(91, 96));
      4: return 8'($urandom_range(123, 127));
      default: return (b < 36) ? digit_char($urandom_range(b, 35))
                               : 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic sender_gap();
    int unsigned n;
    if (!quiet && $urandom_range(0, 99) < 30) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    sender_gap();
  endtask

  task automatic send_text(input bit close);
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) send_char(text_q[i], close && (i == n - 1));
    text_q.delete();
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text(1'b1);
  endtask

  task automatic push_digits(input logic [AccW-1:0] v, input int unsigned b);
    logic [7:0] rev[$];
    do begin
      rev.push_front(digit_char(32'(v % b)));
      v = v / b;
    end while (v != 0);
    if ($urandom_range(0, 4) == 0) text_q.push_back(ChZero);
    foreach (rev[i]) text_q.push_back(rev[i]);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [RadixW-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegRadix) cur_radix = val;
    else cur_wide = val[0];
  endtask

  initial begin
    logic [AccW-1:0]   limit;
    logic [AccW-1:0]   v;
    logic [RadixW-1:0] rad;
    int unsigned       b;
    int unsigned       kind;
    int unsigned       n;
    int unsigned       d;
    int unsigned       phase_left;
    phase_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: radix 10, 64-bit
    send_str("9");
    send_str("a");

    write_reg(RegRadix, RadixMax);
    send_str("zZ");
    send_str("A9");
    text_q.push_back(8'hFF);
    send_text(1'b1);
    text_q.push_back(8'h00);
    text_q.push_back("1");
    send_text(1'b1);
    // characters just outside the digit and letter ranges
    text_q.push_back(8'h2F);
    text_q.push_back(8'h3A);
    text_q.push_back(8'h40);
    text_q.push_back(8'h5B);
    text_q.push_back(8'h60);
    text_q.push_back(8'h7B);
    send_text(1'b1);

    // out-of-range radix clamps to 2 and 36
    write_reg(RegRadix, '0);
    send_str("11");
    write_reg(RegRadix, '1);
    send_str("z");

    // narrow the limit while the accumulator is above 32 bits
    write_reg(RegRadix, RadixMax);
    write_reg(RegWideMode, 6'd1);
    for (int i = 0; i < 7; i++) text_q.push_back((i == 0) ? 8'h33 : ChZero);
    send_text(1'b0);
    write_reg(RegWideMode, 6'd0);
    send_str("0");

    while (sent < TotalItems) begin
      if (phase_left == 0) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) rad = 6'($urandom_range(2, 36));
        else if (kind == 7) rad = RadixMin;
        else if (kind == 8) rad = RadixMax;
        else rad = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(37, 63));
        write_reg(RegRadix, rad);
        write_reg(RegWideMode, {5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))});
        quiet = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(40, 200);
      end
      b = eff_base();
      limit = cur_wide ? '1 : {{(AccW-NarrowW){1'b0}}, {NarrowW{1'b1}}};
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
        repeat (n) text_q.push_back(digit_char($urandom_range(0, b - 1)));
      end else if (kind < 52) begin
        v = {$urandom, $urandom} & limit;
        push_digits(v >> $urandom_range(0, 63), b);
      end else if (kind < 64) begin
        push_digits(limit - 64'($urandom_range(0, 3)), b);
      end else if (kind < 82) begin
        push_digits(limit, b);
        d = 32'(limit % b);
        if (d < b - 1 && $urandom_range(0, 1)) begin
          text_q[text_q.size() - 1] = digit_char($urandom_range(d + 1, b - 1));
        end else begin
          repeat ($urandom_range(1, 4)) text_q.push_back(digit_char($urandom_range(0, b - 1)));
        end
      end else if (kind < 92) begin
        n = $urandom_range(0, 8);
        repeat (n) text_q.push_back(digit_char($urandom_range(0, b - 1)));
        text_q.insert($urandom_range(0, n), bad_char(b));
      end else begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      phase_left = (phase_left > text_q.size()) ? phase_left - text_q.size() : 0;
      send_text(1'b1);
      if ($urandom_range(0, 39) == 0) wait_idle();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
design/rip_pkg.sv
design/rip_front.sv
design/rip_fifo.sv
design/rip_back.sv
design/radix_integer_parser.sv
test/rip_checker.sv
test/tb_top.sv
